[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define AST_SAME(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define AST_NEXT(lbl, clk, rst_n, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pfmd_pkg.sv]
// ----------------------------------------------------------------------------
// pfmd_pkg
// Shared constants and types of the point frame motion detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pfmd_pkg;

    localparam int MAX_POINTS_DEF = 16384;
    localparam int COORD_BITS_DEF = 16;

    localparam int THR_W     = 34;
    localparam int CNT_W     = 15;
    localparam int CFG_IDX_W = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DIST_SQ_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT_CAP         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_COUNT       = 2'd2;

    localparam logic [THR_W-1:0] THR_RESET   = 34'd262144;
    localparam logic [CNT_W-1:0] CAP_RESET   = 15'd5100;
    localparam logic [CNT_W-1:0] ALARM_RESET = 15'd5000;
    localparam logic [CNT_W-1:0] CNT_SAT     = '1;

    // per-point control flags that travel beside the distance pipeline
    typedef struct packed {
        logic elig;
        logic last;
        logic hp;
    } t_ctl;

endpackage

`default_nettype wire

[hw/rtl/pfmd_if.sv]
// ----------------------------------------------------------------------------
// pfmd interfaces
// Point, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfmd_point_if #(
    parameter int CW = pfmd_pkg::COORD_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic                 last_point;

    modport source (output valid, point_x, point_y, point_z, last_point, input ready);
    modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface pfmd_result_if;
    logic                        valid;
    logic                        ready;
    logic                        movement_detected;
    logic [pfmd_pkg::CNT_W-1:0]  moved_count;
    logic                        had_previous;

    modport source (output valid, movement_detected, moved_count, had_previous,
                    input ready);
    modport sink   (input valid, movement_detected, moved_count, had_previous,
                    output ready);
endinterface

interface pfmd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [pfmd_pkg::CFG_IDX_W-1:0] index;
    logic [pfmd_pkg::THR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/pfmd_dist.sv]
// ----------------------------------------------------------------------------
// pfmd_dist
// Three-stage squared distance and threshold compare between two points.
// ----------------------------------------------------------------------------
`default_nettype none

module pfmd_dist #(
    parameter int CW = pfmd_pkg::COORD_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_en,
    input  wire logic [3*CW-1:0]            i_cur,
    input  wire logic [3*CW-1:0]            i_prev,
    input  wire logic [pfmd_pkg::THR_W-1:0] i_thr,
    output logic                            o_over
);

    localparam int SUM_W = 2*CW + 2;
    localparam int CMP_W = (SUM_W > pfmd_pkg::THR_W) ? SUM_W : pfmd_pkg::THR_W;

    logic [CW-1:0]   n_ad [3];
    logic [CW-1:0]   r_ad [3];
    logic [2*CW-1:0] r_sq [3];
    logic [SUM_W-1:0] n_sum;
    logic             r_over;

    for (genvar k = 0; k < 3; k++) begin : g_lane
        logic signed [CW:0] w_diff;
        assign w_diff = $signed({i_cur[k*CW+CW-1], i_cur[k*CW +: CW]})
                      - $signed({i_prev[k*CW+CW-1], i_prev[k*CW +: CW]});
        // magnitude of a difference of two CW-bit values fits CW bits
        always_comb begin
            if (w_diff[CW]) begin
                n_ad[k] = CW'(-w_diff);
            end else begin
                n_ad[k] = w_diff[CW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ad[k] <= n_ad[k];
                r_sq[k] <= r_ad[k] * r_ad[k];
            end
        end
    end

    assign n_sum = SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_over <= CMP_W'(n_sum) > CMP_W'(i_thr);
        end
    end

    assign o_over = r_over;

endmodule

`default_nettype wire

[hw/rtl/point_frame_motion_detector_top.sv]
// A frame's result passes through r_v[0] to r_v[3] and then r_ov once its last point is accepted.
// Throughput: one point per cycle; the point store has one read and one write
// port, each used once per point, and the distance path is a 3-stage pipeline.
// Input stalls only while a finished result waits and the next one is complete.
// Reset clears frame state and sets the registers to their defaults; the point
// store is not cleared, so there is no clearing pass.
// ----------------------------------------------------------------------------
// point_frame_motion_detector_top
// Compares each point with the stored point of the previous frame and flags
// movement when the count of moved points exceeds the alarm level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module point_frame_motion_detector_top #(
    parameter int MAX_POINTS = pfmd_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = pfmd_pkg::COORD_BITS_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    pfmd_point_if.sink    i_point,
    pfmd_result_if.source o_result,
    pfmd_cfg_if.sink      i_cfg
);

    localparam int CW    = COORD_BITS;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int IDX_W = $clog2(MAX_POINTS + 1);
    localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_POINTS);
    localparam int CNT_W = pfmd_pkg::CNT_W;

    // configuration
    logic [pfmd_pkg::THR_W-1:0] r_thr;
    logic [CNT_W-1:0]           r_cap;
    logic [CNT_W-1:0]           r_alarm;

    // front frame state
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] r_plen;
    logic             r_hp;

    // point store
    logic [3*CW-1:0]  r_mem [MAX_POINTS];
    logic [3*CW-1:0]  r_rd;
    logic [3*CW-1:0]  r_cur;
    logic [AW-1:0]    w_addr;
    logic [3*CW-1:0]  w_wdata;

    // pipeline control
    logic             r_v   [4];
    pfmd_pkg::t_ctl   r_ctl [4];
    pfmd_pkg::t_ctl   n_ctl;
    logic             w_adv;
    logic             w_acc;
    logic             w_in_range;
    logic             w_over;

    // back end
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             w_inc;
    logic             r_ov;
    logic             r_mov;
    logic [CNT_W-1:0] r_mcnt;
    logic             r_hpo;

    // stall only when the result stage holds a frame end and the output is full
    assign w_adv = !(r_v[3] && r_ctl[3].last && r_ov && !o_result.ready);
    assign i_point.ready = w_adv;
    assign w_acc = i_point.valid && w_adv;

    assign w_in_range = r_idx < MAX_IDX;
    assign w_addr     = r_idx[AW-1:0];
    assign w_wdata    = {i_point.point_z, i_point.point_y, i_point.point_x};

    always_comb begin
        n_ctl.elig = r_hp && w_in_range && (r_idx < r_plen);
        n_ctl.last = i_point.last_point;
        n_ctl.hp   = r_hp;
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr   <= pfmd_pkg::THR_RESET;
            r_cap   <= pfmd_pkg::CAP_RESET;
            r_alarm <= pfmd_pkg::ALARM_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                pfmd_pkg::REG_DIST_SQ_THRESHOLD: r_thr   <= i_cfg.data;
                pfmd_pkg::REG_COUNT_CAP:         r_cap   <= i_cfg.data[CNT_W-1:0];
                pfmd_pkg::REG_ALARM_COUNT:       r_alarm <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // frame bookkeeping at the point request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx  <= '0;
            r_plen <= '0;
            r_hp   <= 1'b0;
        end else if (w_acc) begin
            if (i_point.last_point) begin
                r_plen <= w_in_range ? r_idx + 1'b1 : r_idx;
                r_idx  <= '0;
                r_hp   <= 1'b1;
            end else if (w_in_range) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    // read old entry and overwrite it in the same cycle
    always_ff @(posedge i_clk) begin
        if (w_acc && w_in_range) begin
            r_mem[w_addr] <= w_wdata;
        end
        if (w_adv) begin
            r_rd  <= r_mem[w_addr];
            r_cur <= w_wdata;
        end
    end

    pfmd_dist #(
        .CW (CW)
    ) u_dist (
        .i_clk  (i_clk),
        .i_en   (w_adv),
        .i_cur  (r_cur),
        .i_prev (r_rd),
        .i_thr  (r_thr),
        .o_over (w_over)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < 4; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (w_adv) begin
            r_v[0] <= w_acc;
            for (int s = 1; s < 4; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ctl[0] <= n_ctl;
            for (int s = 1; s < 4; s++) begin
                r_ctl[s] <= r_ctl[s-1];
            end
        end
    end

    // counting happens in order at the last stage, so the cap test is exact
    assign w_inc = r_ctl[3].elig && w_over && (r_cnt < r_cap) && (r_cnt != pfmd_pkg::CNT_SAT);
    assign n_cnt = w_inc ? r_cnt + 1'b1 : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (w_adv && r_v[3]) begin
                r_cnt <= r_ctl[3].last ? '0 : n_cnt;
            end
            if (w_adv && r_v[3] && r_ctl[3].last) begin
                r_ov <= 1'b1;
            end else if (o_result.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_v[3] && r_ctl[3].last) begin
            r_mov  <= r_ctl[3].hp && (n_cnt > r_alarm);
            r_mcnt <= n_cnt;
            r_hpo  <= r_ctl[3].hp;
        end
    end

    assign o_result.valid             = r_ov;
    assign o_result.movement_detected = r_mov;
    assign o_result.moved_count       = r_mcnt;
    assign o_result.had_previous      = r_hpo;

    `AST_SAME(a_idx_bound, i_clk, i_rst_n, 1'b1, r_idx <= MAX_IDX, "point index past store depth")
    `AST_NEXT(a_frame_restart, i_clk, i_rst_n, w_acc && i_point.last_point, r_idx == '0, "index not restarted after frame end")
    `AST_SAME(a_first_frame_quiet, i_clk, i_rst_n, o_result.valid && !o_result.had_previous, !o_result.movement_detected && o_result.moved_count == '0, "first frame reported movement")
    `AST_SAME(a_no_count_before_prev, i_clk, i_rst_n, !r_hp, r_cnt == '0, "points counted before a previous frame exists")

endmodule

`default_nettype wire
